@@ design/tccw_pkg.sv @@
package tccw_pkg;

	// field widths
	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int BYTE_W = 8;
	localparam int CELL_W = 16;

	// command codes
	localparam logic [1:0] CMD_PUT   = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	// control characters
	localparam logic [BYTE_W-1:0] CH_LF = 8'd10;
	localparam logic [BYTE_W-1:0] CH_CR = 8'd13;
	localparam logic [BYTE_W-1:0] CH_BS = 8'd8;

	// attribute after reset
	localparam logic [BYTE_W-1:0] ATTR_RESET = 8'h0F;

	// engine sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_WRITE,
		ST_COPY,
		ST_FLUSH,
		ST_BLANK,
		ST_CLEAR,
		ST_DONE
	} state_t;

	// one result transaction
	typedef struct packed {
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic [BYTE_W-1:0] cchar;
		logic [BYTE_W-1:0] cattr;
	} result_t;

endpackage

@@ design/tccw_cell_ram.sv @@
module tccw_cell_ram import tccw_pkg::*; #(
	parameter int DEPTH = 2000,
	parameter int AW    = 11
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [CELL_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output logic [CELL_W-1:0] rd_data
);

	logic [CELL_W-1:0] mem_q [DEPTH];
	logic [CELL_W-1:0] rd_data_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ design/tccw_engine.sv @@
module tccw_engine import tccw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25,
	parameter int AW      = 11
) (
	input  logic              clk,
	input  logic              arst_n,
	// command transaction
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        cmd,
	input  logic [BYTE_W-1:0] char_code,
	input  logic [COL_W-1:0]  read_col,
	input  logic [ROW_W-1:0]  read_row,
	// attribute register
	input  logic              cfg_wr_en,
	input  logic [BYTE_W-1:0] cfg_wr_data,
	// finished result
	output logic              res_valid,
	input  logic              res_take,
	output result_t           res,
	// cell store
	output logic              mem_we,
	output logic [AW-1:0]     mem_waddr,
	output logic [CELL_W-1:0] mem_wdata,
	output logic              mem_re,
	output logic [AW-1:0]     mem_raddr,
	input  logic [CELL_W-1:0] mem_rdata
);

	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam logic [AW-1:0] COPY_LAST = AW'(COLUMNS * (ROWS - 1) - 1);
	localparam logic [AW-1:0] CELL_LAST = AW'(CELL_COUNT - 1);
	localparam logic [AW-1:0] ROW_STEP  = AW'(COLUMNS);

	state_t state_q, state_d;

	logic [1:0]        cmd_q;
	logic [BYTE_W-1:0] char_q;
	logic [COL_W-1:0]  rcol_q;
	logic [ROW_W-1:0]  rrow_q;
	logic              rd_hit_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  line_q;
	logic [BYTE_W-1:0] attr_q;
	logic [AW-1:0]     cnt_q;
	logic              cp_pend_q;
	logic [AW-1:0]     cp_addr_q;

	logic              is_ctrl_char;
	logic              line_full;
	logic [COL_W:0]    col_inc;
	logic [AW-1:0]     cursor_addr;
	logic [AW-1:0]     read_addr;

	assign is_ctrl_char = (char_q == CH_LF) || (char_q == CH_CR) || (char_q == CH_BS);
	assign line_full    = (line_q == ROW_W'(ROWS));
	assign col_inc      = {1'b0, col_q} + 8'd1;
	assign cursor_addr  = AW'(line_q) * ROW_STEP + AW'(col_q);
	assign read_addr    = AW'(rrow_q) * ROW_STEP + AW'(rcol_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				unique case (cmd_q)
					CMD_PUT: begin
						priority if (is_ctrl_char) state_d = ST_DONE;
						else if (line_full) state_d = ST_COPY;
						else state_d = ST_WRITE;
					end
					CMD_CLEAR: state_d = ST_CLEAR;
					default:   state_d = ST_DONE;
				endcase
			end
			ST_WRITE: state_d = ST_DONE;
			ST_COPY: begin
				if (cnt_q == COPY_LAST) state_d = ST_FLUSH;
			end
			ST_FLUSH: state_d = ST_BLANK;
			ST_BLANK: begin
				if (cnt_q == CELL_LAST) state_d = ST_WRITE;
			end
			ST_CLEAR: begin
				if (cnt_q == CELL_LAST) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (res_take) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// store accesses and handshake
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cnt_q;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = cnt_q + ROW_STEP;
		in_stall  = (state_q != ST_IDLE);
		res_valid = (state_q == ST_DONE);
		unique case (state_q)
			ST_DISPATCH: begin
				mem_re    = rd_hit_q;
				mem_raddr = read_addr;
			end
			ST_WRITE: begin
				mem_we    = 1'b1;
				mem_waddr = cursor_addr;
				mem_wdata = {attr_q, char_q};
			end
			// read one row below, write back the cell fetched last cycle
			ST_COPY: begin
				mem_re    = 1'b1;
				mem_we    = cp_pend_q;
				mem_waddr = cp_addr_q;
				mem_wdata = mem_rdata;
			end
			ST_FLUSH: begin
				mem_we    = 1'b1;
				mem_waddr = cp_addr_q;
				mem_wdata = mem_rdata;
			end
			ST_BLANK: begin
				mem_we = 1'b1;
			end
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_wdata = {attr_q, 8'h00};
			end
			default: begin
			end
		endcase
	end

	assign res.col   = col_q;
	assign res.row   = line_q;
	assign res.cchar = rd_hit_q ? mem_rdata[BYTE_W-1:0] : '0;
	assign res.cattr = rd_hit_q ? mem_rdata[CELL_W-1:BYTE_W] : '0;

	// control state: sequencer, cursor, attribute
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			col_q     <= '0;
			line_q    <= '0;
			attr_q    <= ATTR_RESET;
			rd_hit_q  <= 1'b0;
			cp_pend_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			cp_pend_q <= (state_q == ST_COPY);
			if (cfg_wr_en) attr_q <= cfg_wr_data;
			if (state_q == ST_IDLE && in_valid) begin
				rd_hit_q <= (cmd == CMD_READ) && ({1'b0, read_col} < 8'(COLUMNS))
					&& ({1'b0, read_row} < 6'(ROWS));
			end
			unique case (state_q)
				ST_DISPATCH: begin
					if (cmd_q == CMD_PUT) begin
						priority if (char_q == CH_LF) begin
							if (!line_full) line_q <= line_q + 5'd1;
						end else if (char_q == CH_CR) begin
							col_q <= '0;
						end else if (char_q == CH_BS) begin
							if (col_q != '0) col_q <= col_q - 7'd1;
						end else begin
						end
					end
				end
				ST_WRITE: begin
					if (col_inc == 8'(COLUMNS)) begin
						col_q  <= '0;
						line_q <= line_q + 5'd1;
					end else begin
						col_q <= col_inc[COL_W-1:0];
					end
				end
				ST_BLANK: begin
					if (cnt_q == CELL_LAST) line_q <= line_q - 5'd1;
				end
				ST_CLEAR: begin
					col_q  <= '0;
					line_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// command payload and sweep counter
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			cmd_q  <= cmd;
			char_q <= char_code;
			rcol_q <= read_col;
			rrow_q <= read_row;
		end
		cp_addr_q <= cnt_q;
		if (state_q == ST_DISPATCH) begin
			cnt_q <= '0;
		end else if (state_q == ST_COPY || state_q == ST_BLANK || state_q == ST_CLEAR) begin
			cnt_q <= cnt_q + AW'(1);
		end
	end

endmodule

@@ design/text_console_char_writer.sv @@
// Channel   Direction  Handshake          Payload
// command   in         in_valid/in_stall  cmd, char_code, read_col, read_row
// result    out        out_valid/out_stall cursor_col, cursor_row, cell_char, cell_attr
// attribute in         cfg_wr_en          cfg_wr_data
//
// Printable put: accept, dispatch, cell write, result load; control characters and reads
// skip the cell write. A put at a pending scroll first shifts rows up one and blanks the
// bottom row; clear writes every cell. Both sweep the cell store at its single write port,
// one cell per cycle. Reset zeroes the cursor and sets the attribute to ATTR_RESET; cells
// are undefined until written. A stalled result sits in the output register while the
// next command is taken; the engine waits in its done step until that register is free.
module text_console_char_writer import tccw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        cmd,
	input  logic [BYTE_W-1:0] char_code,
	input  logic [COL_W-1:0]  read_col,
	input  logic [ROW_W-1:0]  read_row,
	input  logic              cfg_wr_en,
	input  logic [BYTE_W-1:0] cfg_wr_data,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [COL_W-1:0]  cursor_col,
	output logic [ROW_W-1:0]  cursor_row,
	output logic [BYTE_W-1:0] cell_char,
	output logic [BYTE_W-1:0] cell_attr
);

	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int AW         = $clog2(CELL_COUNT);

	logic              res_valid;
	logic              res_take;
	result_t           res;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [CELL_W-1:0] mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic [CELL_W-1:0] mem_rdata;
	logic              out_valid_q;
	result_t           res_q;

	tccw_engine #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS),
		.AW     (AW)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.char_code  (char_code),
		.read_col   (read_col),
		.read_row   (read_row),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.res_valid  (res_valid),
		.res_take   (res_take),
		.res        (res),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	tccw_cell_ram #(
		.DEPTH(CELL_COUNT),
		.AW   (AW)
	) u_cell_ram (
		.clk    (clk),
		.wr_en  (mem_we),
		.wr_addr(mem_waddr),
		.wr_data(mem_wdata),
		.rd_en  (mem_re),
		.rd_addr(mem_raddr),
		.rd_data(mem_rdata)
	);

	// output register
	assign res_take = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) res_q <= res;
	end

	assign out_valid  = out_valid_q;
	assign cursor_col = res_q.col;
	assign cursor_row = res_q.row;
	assign cell_char  = res_q.cchar;
	assign cell_attr  = res_q.cattr;

`ifndef ASSERT_OFF
	// engine goes busy right after taking a command
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("engine took a command but did not go busy");

	// reported row never passes the scroll-pending value
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cursor_row <= ROW_W'(ROWS)))
		else $error("cursor row out of range");

	// no write lands outside the cell store
	a_waddr_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (mem_waddr <= AW'(CELL_COUNT - 1)))
		else $error("cell write address out of range");

	// scroll copy never reads and writes the same cell in one cycle
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_re) |-> (mem_waddr != mem_raddr))
		else $error("read and write of the same cell in one cycle");
`endif

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import tccw_pkg::*;

	localparam int COLUMNS       = 80;
	localparam int ROWS          = 25;
	localparam int CELLS         = COLUMNS * ROWS;
	localparam int HALF_PERIOD   = 6;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_ITEMS   = 530;
	// scroll and clear walk the whole store; allow for far more of them than the mix makes
	localparam int LIMIT_NS      = 20_000_000 * 2 * HALF_PERIOD;

	// code the block does not define; it must leave state alone
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [1:0]        cmd;
	logic [BYTE_W-1:0] char_code;
	logic [COL_W-1:0]  read_col;
	logic [ROW_W-1:0]  read_row;
	logic              cfg_wr_en;
	logic [BYTE_W-1:0] cfg_wr_data;
	logic              out_valid;
	logic              out_stall;
	logic [COL_W-1:0]  cursor_col;
	logic [ROW_W-1:0]  cursor_row;
	logic [BYTE_W-1:0] cell_char;
	logic [BYTE_W-1:0] cell_attr;

	text_console_char_writer #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.char_code  (char_code),
		.read_col   (read_col),
		.read_row   (read_row),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.cursor_col (cursor_col),
		.cursor_row (cursor_row),
		.cell_char  (cell_char),
		.cell_attr  (cell_attr)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// shadow of the console: frame store, cursor, attribute register
	logic [CELL_W-1:0] frame_store [0:CELLS-1];
	int                cur_col;
	int                cur_row;
	logic [BYTE_W-1:0] text_attr;

	result_t pending_results [$];

	int sender_idle_pct;
	int receiver_idle_pct;
	int fail_count;
	int items_sent;
	int reads_sent;
	int clears_sent;
	int scroll_count;
	int results_checked;

	// one directed transaction; res is used only where typed is set
	typedef struct {
		logic [1:0]        op;
		logic [BYTE_W-1:0] ch;
		logic [COL_W-1:0]  rcol;
		logic [ROW_W-1:0]  rrow;
		bit                set_attr;
		logic [BYTE_W-1:0] attr_val;
		bit                typed;
		result_t           res;
	} plan_item_t;

	plan_item_t directed_plan [$];

	// console behavior for one command; updates the shadow state
	function automatic result_t console_step(input logic [1:0] op, input logic [BYTE_W-1:0] ch,
			input logic [COL_W-1:0] rc, input logic [ROW_W-1:0] rr);
		result_t r;
		int      i;
		r = '0;
		case (op)
			CMD_PUT: begin
				if (ch == CH_LF) begin
					if (cur_row < ROWS)
						cur_row++;
				end else if (ch == CH_CR) begin
					cur_col = 0;
				end else if (ch == CH_BS) begin
					if (cur_col > 0)
						cur_col--;
				end else begin
					// pending scroll: shift rows up, blank the bottom row
					if (cur_row >= ROWS) begin
						for (i = 0; i < COLUMNS * (ROWS - 1); i++)
							frame_store[i] = frame_store[i + COLUMNS];
						for (i = COLUMNS * (ROWS - 1); i < CELLS; i++)
							frame_store[i] = '0;
						cur_row--;
						scroll_count++;
					end
					frame_store[cur_row * COLUMNS + cur_col] = {text_attr, ch};
					cur_col++;
					if (cur_col >= COLUMNS) begin
						cur_col = 0;
						cur_row++;
					end
				end
			end
			CMD_CLEAR: begin
				for (i = 0; i < CELLS; i++)
					frame_store[i] = {text_attr, 8'h00};
				cur_col = 0;
				cur_row = 0;
			end
			CMD_READ: begin
				if (rc < COLUMNS && rr < ROWS) begin
					r.cchar = frame_store[rr * COLUMNS + rc][7:0];
					r.cattr = frame_store[rr * COLUMNS + rc][15:8];
				end
			end
			default: ;
		endcase
		r.col = cur_col[COL_W-1:0];
		r.row = cur_row[ROW_W-1:0];
		return r;
	endfunction

	// drive one command transaction; entered and left at a falling edge
	task automatic send_cmd(input logic [1:0] op, input logic [BYTE_W-1:0] ch,
			input logic [COL_W-1:0] rc, input logic [ROW_W-1:0] rr,
			input bit typed, input result_t typed_res);
		result_t model_res;
		while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		cmd       <= op;
		char_code <= ch;
		read_col  <= rc;
		read_row  <= rr;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		model_res = console_step(op, ch, rc, rr);
		pending_results.push_back(typed ? typed_res : model_res);
		items_sent++;
		if (op == CMD_READ)
			reads_sent++;
		if (op == CMD_CLEAR)
			clears_sent++;
		@(negedge clk);
	endtask

	// hold the command side until every result is back and the engine is quiet
	task automatic wait_results_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// attribute write while the block is idle
	task automatic set_attribute(input logic [BYTE_W-1:0] value);
		wait_results_drained();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		text_attr = value;
	endtask

	task automatic plan_item(input logic [1:0] op, input logic [BYTE_W-1:0] ch,
			input logic [COL_W-1:0] rc, input logic [ROW_W-1:0] rr,
			input bit set_attr, input logic [BYTE_W-1:0] attr_val,
			input bit typed, input result_t res);
		plan_item_t p;
		p.op       = op;
		p.ch       = ch;
		p.rcol     = rc;
		p.rrow     = rr;
		p.set_attr = set_attr;
		p.attr_val = attr_val;
		p.typed    = typed;
		p.res      = res;
		directed_plan.push_back(p);
	endtask

	// text lines, reads, noise and clears with random content
	task automatic random_phase(input int n_items, input int snd_pct, input int rcv_pct);
		int start;
		int pick;
		int len;
		int k;
		int tail;
		sender_idle_pct   = snd_pct;
		receiver_idle_pct = rcv_pct;
		start = items_sent;
		while (items_sent - start < n_items) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				// a line of text, mostly short, now and then past the right edge
				len = ($urandom_range(9) == 0) ? $urandom_range(60, 100) : $urandom_range(0, 20);
				for (k = 0; k < len; k++) begin
					if ($urandom_range(11) == 0)
						send_cmd(CMD_PUT, CH_BS, COL_W'($urandom_range(127)),
							ROW_W'($urandom_range(31)), 1'b0, '0);
					else
						send_cmd(CMD_PUT, BYTE_W'($urandom_range(255)),
							COL_W'($urandom_range(127)), ROW_W'($urandom_range(31)), 1'b0, '0);
				end
				tail = $urandom_range(9);
				if (tail <= 5) begin
					send_cmd(CMD_PUT, CH_CR, COL_W'($urandom_range(127)),
						ROW_W'($urandom_range(31)), 1'b0, '0);
					send_cmd(CMD_PUT, CH_LF, COL_W'($urandom_range(127)),
						ROW_W'($urandom_range(31)), 1'b0, '0);
				end else if (tail <= 7) begin
					send_cmd(CMD_PUT, CH_LF, COL_W'($urandom_range(127)),
						ROW_W'($urandom_range(31)), 1'b0, '0);
				end else if (tail == 8) begin
					repeat (3)
						send_cmd(CMD_PUT, CH_LF, COL_W'($urandom_range(127)),
							ROW_W'($urandom_range(31)), 1'b0, '0);
				end
			end else if (pick < 85) begin
				// cell reads, a few of them outside the screen
				repeat ($urandom_range(1, 4)) begin
					if ($urandom_range(99) < 15)
						send_cmd(CMD_READ, BYTE_W'($urandom_range(255)),
							COL_W'($urandom_range(127)), ROW_W'($urandom_range(31)), 1'b0, '0);
					else
						send_cmd(CMD_READ, BYTE_W'($urandom_range(255)),
							COL_W'($urandom_range(COLUMNS - 1)),
							ROW_W'($urandom_range(ROWS - 1)), 1'b0, '0);
				end
			end else if (pick < 93) begin
				// noise: any code, any fields
				repeat ($urandom_range(1, 3))
					send_cmd(2'($urandom_range(3)), BYTE_W'($urandom_range(255)),
						COL_W'($urandom_range(127)), ROW_W'($urandom_range(31)), 1'b0, '0);
			end else if (pick < 96) begin
				send_cmd(CMD_CLEAR, BYTE_W'($urandom_range(255)), COL_W'($urandom_range(127)),
					ROW_W'($urandom_range(31)), 1'b0, '0);
			end else begin
				wait_results_drained();
			end
		end
	endtask

	// receiver back-pressure
	always @(negedge clk)
		out_stall <= (receiver_idle_pct != 0) && ($urandom_range(99) < receiver_idle_pct);

	// result checker: oldest expectation against each accepted result transaction
	always @(posedge clk) begin
		result_t want;
		if (out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result with no command outstanding: col %0d row %0d char %0d attr %0d",
					cursor_col, cursor_row, cell_char, cell_attr);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (cursor_col !== want.col) begin
					$error("cursor_col: expected %0d, got %0d", want.col, cursor_col);
					fail_count++;
				end
				if (cursor_row !== want.row) begin
					$error("cursor_row: expected %0d, got %0d", want.row, cursor_row);
					fail_count++;
				end
				if (cell_char !== want.cchar) begin
					$error("cell_char: expected %0d, got %0d", want.cchar, cell_char);
					fail_count++;
				end
				if (cell_attr !== want.cattr) begin
					$error("cell_attr: expected %0d, got %0d", want.cattr, cell_attr);
					fail_count++;
				end
			end
		end
	end

	// run limit
	initial begin
		#(LIMIT_NS);
		$display("testbench: errors");
		$finish;
	end

	initial begin
		int idx;
		arst_n            = 1'b0;
		in_valid          = 1'b0;
		cmd               = CMD_PUT;
		char_code         = '0;
		read_col          = '0;
		read_row          = '0;
		cfg_wr_en         = 1'b0;
		cfg_wr_data       = '0;
		out_stall         = 1'b0;
		sender_idle_pct   = 19;
		receiver_idle_pct = 66;
		fail_count        = 0;
		items_sent        = 0;
		reads_sent        = 0;
		clears_sent       = 0;
		scroll_count      = 0;
		results_checked   = 0;
		cur_col           = 0;
		cur_row           = 0;
		text_attr         = ATTR_RESET;

		// directed: out-of-range reads and the unused code before anything is written,
		// then clear, reads at the corners and just outside, puts, control characters, attribute extremes
		plan_item(CMD_READ,   8'h00, 7'd127, 5'd31, 1'b0, 8'h00, 1'b1, '{7'd0, 5'd0, 8'h00, 8'h00});
		plan_item(CMD_UNUSED, 8'hFF, 7'd127, 5'd31, 1'b0, 8'h00, 1'b1, '{7'd0, 5'd0, 8'h00, 8'h00});
		plan_item(CMD_CLEAR,  8'hFF, 7'd127, 5'd31, 1'b0, 8'h00, 1'b1, '{7'd0, 5'd0, 8'h00, 8'h00});
		plan_item(CMD_READ,   8'h00, 7'd0,   5'd0,  1'b0, 8'h00, 1'b1,
			'{7'd0, 5'd0, 8'h00, ATTR_RESET});
		plan_item(CMD_READ,   8'hFF, 7'd79,  5'd24, 1'b0, 8'h00, 1'b1,
			'{7'd0, 5'd0, 8'h00, ATTR_RESET});
		plan_item(CMD_READ,   8'h00, 7'd80,  5'd0,  1'b0, 8'h00, 1'b1, '{7'd0, 5'd0, 8'h00, 8'h00});
		plan_item(CMD_READ,   8'h00, 7'd0,   5'd25, 1'b0, 8'h00, 1'b1, '{7'd0, 5'd0, 8'h00, 8'h00});
		plan_item(CMD_PUT,    8'h41, 7'd0,   5'd0,  1'b0, 8'h00, 1'b1, '{7'd1, 5'd0, 8'h00, 8'h00});
		plan_item(CMD_READ,   8'h00, 7'd0,   5'd0,  1'b0, 8'h00, 1'b1,
			'{7'd1, 5'd0, 8'h41, ATTR_RESET});
		plan_item(CMD_PUT,    8'hFF, 7'd127, 5'd31, 1'b0, 8'h00, 1'b0, '0);
		plan_item(CMD_PUT,    8'h00, 7'd0,   5'd0,  1'b0, 8'h00, 1'b0, '0);
		plan_item(CMD_PUT,    CH_BS, 7'd0,   5'd0,  1'b0, 8'h00, 1'b0, '0);
		plan_item(CMD_PUT,    CH_BS, 7'd0,   5'd0,  1'b0, 8'h00, 1'b0, '0);
		plan_item(CMD_PUT,    CH_BS, 7'd0,   5'd0,  1'b0, 8'h00, 1'b0, '0);
		plan_item(CMD_PUT,    CH_BS, 7'd0,   5'd0,  1'b0, 8'h00, 1'b0, '0);
		plan_item(CMD_PUT,    8'h80, 7'd0,   5'd0,  1'b1, 8'h00, 1'b0, '0);
		plan_item(CMD_READ,   8'h00, 7'd0,   5'd0,  1'b0, 8'h00, 1'b0, '0);
		plan_item(CMD_PUT,    CH_CR, 7'd0,   5'd0,  1'b0, 8'h00, 1'b0, '0);
		plan_item(CMD_PUT,    CH_LF, 7'd0,   5'd0,  1'b0, 8'h00, 1'b0, '0);
		plan_item(CMD_PUT,    8'h7F, 7'd0,   5'd0,  1'b1, 8'hFF, 1'b0, '0);
		plan_item(CMD_READ,   8'h00, 7'd0,   5'd1,  1'b0, 8'h00, 1'b0, '0);
		plan_item(CMD_CLEAR,  8'h00, 7'd0,   5'd0,  1'b0, 8'h00, 1'b0, '0);
		plan_item(CMD_READ,   8'h00, 7'd79,  5'd24, 1'b0, 8'h00, 1'b0, '0);
		plan_item(CMD_PUT,    CH_LF, 7'd64,  5'd16, 1'b0, 8'h00, 1'b0, '0);

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (idx = 0; idx < directed_plan.size(); idx++) begin
			if (directed_plan[idx].set_attr)
				set_attribute(directed_plan[idx].attr_val);
			send_cmd(directed_plan[idx].op, directed_plan[idx].ch, directed_plan[idx].rcol,
				directed_plan[idx].rrow, directed_plan[idx].typed, directed_plan[idx].res);
		end

		// random phases, attribute changed between them
		set_attribute(8'h00);
		random_phase(PHASE_ITEMS, 19, 66);
		set_attribute(BYTE_W'($urandom_range(1, 254)));
		random_phase(PHASE_ITEMS, 66, 19);
		set_attribute(8'hFF);
		random_phase(PHASE_ITEMS, 0, 0);

		wait_results_drained();
		$display("run: %0d commands (%0d reads, %0d clears), %0d scrolls, %0d results compared",
			items_sent, reads_sent, clears_sent, scroll_count, results_checked);
		$display("run: attribute set to 0, 255 and a random value; sender and receiver stalls");
		if (fail_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

@@ files.f @@
design/tccw_pkg.sv
design/tccw_cell_ram.sv
design/tccw_engine.sv
design/text_console_char_writer.sv
sim/testbench.sv
